>>> hdl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg - shared types and constants
// Entry and command formats, request and status codes, register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

   localparam int DefaultCapacity = 16;
   localparam int DateW           = 27;
   localparam int CodeW           = 31;
   localparam int CountOutW       = 5;
   localparam int ClassW          = 2;
   localparam int CsrAddrW        = 4;
   localparam int CsrDataW        = 32;

   localparam logic [DateW-1:0] TodayReset = 27'd20240427;
   localparam logic [DateW-1:0] ElderReset = 27'd800000;
   localparam logic [DateW-1:0] ChildReset = 27'd100000;

   localparam logic [ClassW-1:0] ClassTop    = 2'd0;
   localparam logic [ClassW-1:0] ClassMiddle = 2'd1;
   localparam logic [ClassW-1:0] ClassBottom = 2'd2;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_POP_HEAD = 2'd1,
      REQ_POP_TAIL = 2'd2,
      REQ_PEEK     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_TODAY = 2'd0,
      REG_ELDER = 2'd1,
      REG_CHILD = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP_HEAD,
      OP_POP_TAIL
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [ClassW-1:0] cls;
      logic [DateW-1:0]  date;
      logic [CodeW-1:0]  code;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      logic [ClassW-1:0] cls;
      logic [DateW-1:0]  date;
      logic [CodeW-1:0]  code;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> hdl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// tcpq_cell - one slot of the sorted entry chain
// Holds one entry; shifts towards the tail on insert, towards the head on a
// head removal, and drops itself when it is the last valid slot on a tail
// removal. Entries stay ordered by class, then by arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_cell
   import tcpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire entry_type    left,
   input  wire entry_type    right,
   output entry_type         entry,
   output entry_type         entry_next
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      my_after;
   logic      left_after;

   assign my_after   = !entry_ff.valid || (entry_ff.cls > cmd.cls);
   assign left_after = !left.valid || (left.cls > cmd.cls);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (my_after) begin
               if (left_after) begin
                  entry_in = left;
               end else begin
                  entry_in.valid = 1'b1;
                  entry_in.cls   = cmd.cls;
                  entry_in.date  = cmd.date;
                  entry_in.code  = cmd.code;
               end
            end
         end
         OP_POP_HEAD: entry_in = right;
         OP_POP_TAIL: begin
            if (entry_ff.valid && !right.valid) begin
               entry_in.valid = 1'b0;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.cls  <= entry_in.cls;
      entry_ff.date <= entry_in.date;
      entry_ff.code <= entry_in.code;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

>>> hdl/three_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue_top - three-class strict priority queue
// The result beat is registered and offered in the cycle after its request beat is accepted.
// Throughput: one request per cycle while result beats are taken; each
//   request updates every cell of the chain on the same clock edge.
// Reset: empties the queue and returns the date and thresholds to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_priority_queue_top
   import tcpq_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [63:0]         req_tdata,   // birth_date, patient_code, pad
   input  wire logic [1:0]          req_tuser,   // req_type
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [63:0]              rsp_tdata,   // head_date, head_code, entry_count, pad
   output logic [1:0]               rsp_tuser,   // status
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready
);

   localparam int CountW = $clog2(CAPACITY + 1);

   logic [DateW-1:0]  today_ff;
   logic [DateW-1:0]  elder_ff;
   logic [DateW-1:0]  child_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   req_kind_type      req_kind;
   logic [DateW-1:0]  req_date;
   logic [CodeW-1:0]  req_code;
   logic              req_accept;

   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic              full;
   logic              empty;
   logic signed [DateW+1:0] age;
   logic [ClassW-1:0] new_cls;
   status_type        status;
   cell_cmd_type      cmd;

   entry_type         chain [CAPACITY+2];
   entry_type         head_next;
   logic [CAPACITY-1:0] valid_vec;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [DateW-1:0]  rsp_date_ff;
   logic [CodeW-1:0]  rsp_code_ff;
   logic [CountW-1:0] rsp_count_ff;
   logic [CountW+CountOutW-1:0] rsp_count_wide;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         today_ff <= TodayReset;
         elder_ff <= ElderReset;
         child_ff <= ChildReset;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TODAY: today_ff <= csr_pwdata[DateW-1:0];
            REG_ELDER: elder_ff <= csr_pwdata[DateW-1:0];
            REG_CHILD: child_ff <= csr_pwdata[DateW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TODAY: csr_prdata = {{(CsrDataW-DateW){1'b0}}, today_ff};
         REG_ELDER: csr_prdata = {{(CsrDataW-DateW){1'b0}}, elder_ff};
         REG_CHILD: csr_prdata = {{(CsrDataW-DateW){1'b0}}, child_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // request decode
   assign req_kind   = req_kind_type'(req_tuser);
   assign req_date   = req_tdata[DateW-1:0];
   assign req_code   = req_tdata[DateW+CodeW-1:DateW];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign full  = (count_ff == CountW'(CAPACITY));
   assign empty = (count_ff == '0);

   assign age = $signed({2'b00, today_ff}) - $signed({2'b00, req_date});

   always_comb begin
      if (age > $signed({2'b00, elder_ff})) begin
         new_cls = ClassTop;
      end else if (age < $signed({2'b00, child_ff})) begin
         new_cls = ClassMiddle;
      end else begin
         new_cls = ClassBottom;
      end
   end

   always_comb begin
      cmd.op   = OP_HOLD;
      cmd.cls  = new_cls;
      cmd.date = req_date;
      cmd.code = req_code;
      status   = ST_OK;
      count_in = count_ff;
      if (req_accept) begin
         unique case (req_kind)
            REQ_INSERT: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  cmd.op   = OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_POP_HEAD, REQ_POP_TAIL: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  cmd.op   = (req_kind == REQ_POP_HEAD) ? OP_POP_HEAD : OP_POP_TAIL;
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_PEEK: begin
               if (empty) begin
                  status = ST_EMPTY;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // cell chain: a top-class sentinel before the head, an empty slot after the tail
   assign chain[0] = '{valid: 1'b1, cls: ClassTop, date: '0, code: '0};
   assign chain[CAPACITY+1] = '{valid: 1'b0, cls: ClassTop, date: '0, code: '0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type nxt;
      tcpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left       (chain[i]),
         .right      (chain[i+2]),
         .entry      (chain[i+1]),
         .entry_next (nxt)
      );
      assign valid_vec[i] = chain[i+1].valid;
   end

   assign head_next = g_cell[0].nxt;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= status;
         rsp_date_ff   <= head_next.valid ? head_next.date : '0;
         rsp_code_ff   <= head_next.valid ? head_next.code : '0;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_count_wide = {{CountOutW{1'b0}}, rsp_count_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_count_wide[CountOutW-1:0], rsp_code_ff, rsp_date_ff};

   // checks
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count differs from occupied cells");

   a_packed_chain: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("occupied cells are not contiguous from the head");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == REQ_INSERT && !full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not add an entry");

   a_head_top_class: assert property (@(posedge clock) disable iff (reset)
      (chain[1].valid && chain[2].valid) |-> chain[1].cls <= chain[2].cls)
      else $error("head is not of the lowest class");

endmodule

`default_nettype wire

>>> verif/three_class_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue_top_tb - self-checking bench for the priority queue
// Drives request beats through empty, full and mixed-class states under
// several date and threshold settings. Predicts each result beat and checks
// it field by field. Idles the sender and stalls the receiver at random.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_priority_queue_top_tb;
   import tcpq_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int PhaseItems = 180;
   localparam logic [1:0] RegUnused = 2'd3;
   localparam logic [DateW-1:0] DateMax = 27'd99991231;

   typedef struct packed {
      status_type           status;
      logic [DateW-1:0]     head_date;
      logic [CodeW-1:0]     head_code;
      logic [CountOutW-1:0] count;
   } head_report_type;

   class head_report_board;
      logic [DateW-1:0] today_date;
      logic [DateW-1:0] elder_limit;
      logic [DateW-1:0] child_limit;
      logic [DateW-1:0] key_mem [3][DefaultCapacity];
      logic [CodeW-1:0] code_mem [3][DefaultCapacity];
      int unsigned      head_ptr [3];
      int unsigned      class_count [3];
      int unsigned      held;
      head_report_type  pending_reports [$];
      int               mismatch_count;

      function new();
         today_date  = TodayReset;
         elder_limit = ElderReset;
         child_limit = ChildReset;
         held = 0;
         mismatch_count = 0;
         foreach (head_ptr[c]) begin
            head_ptr[c] = 0;
            class_count[c] = 0;
         end
      endfunction

      function void set_register(logic [1:0] index, logic [DateW-1:0] value);
         case (index)
            REG_TODAY: today_date = value;
            REG_ELDER: elder_limit = value;
            REG_CHILD: child_limit = value;
            default: ;
         endcase
      endfunction

      function void complain(string text);
         mismatch_count++;
         if (mismatch_count <= 10) $display("mismatch: %s", text);
      endfunction

      function void check_register(logic [1:0] index, logic [CsrDataW-1:0] got);
         logic [DateW-1:0] want;
         want = (index == REG_TODAY) ? today_date :
                (index == REG_ELDER) ? elder_limit : child_limit;
         if (got !== {5'd0, want})
            complain($sformatf("register %0d read %0d, want %0d", index, got, want));
      endfunction

      function logic [ClassW-1:0] class_for(logic [DateW-1:0] birth);
         longint age;
         longint elder;
         longint child;
         age   = longint'({37'd0, today_date}) - longint'({37'd0, birth});
         elder = {37'd0, elder_limit};
         child = {37'd0, child_limit};
         if (age > elder) return ClassTop;
         if (age < child) return ClassMiddle;
         return ClassBottom;
      endfunction

      function int top_class();
         for (int c = 0; c < 3; c++)
            if (class_count[c] != 0) return c;
         return -1;
      endfunction

      function void note_request(req_kind_type kind, logic [DateW-1:0] birth,
                                 logic [CodeW-1:0] code);
         head_report_type  r;
         logic [ClassW-1:0] cls;
         int unsigned      slot;
         int               c;
         int               victim;
         r.status = ST_OK;
         case (kind)
            REQ_INSERT: begin
               if (held >= DefaultCapacity) begin
                  r.status = ST_FULL;
               end else begin
                  cls  = class_for(birth);
                  slot = (head_ptr[cls] + class_count[cls]) % DefaultCapacity;
                  key_mem[cls][slot]  = birth;
                  code_mem[cls][slot] = code;
                  class_count[cls]++;
                  held++;
               end
            end
            REQ_POP_HEAD: begin
               c = top_class();
               if (c < 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  head_ptr[c] = (head_ptr[c] + 1) % DefaultCapacity;
                  class_count[c]--;
                  held--;
               end
            end
            REQ_POP_TAIL: begin
               victim = -1;
               for (c = 2; c >= 0; c--)
                  if (victim < 0 && class_count[c] != 0) victim = c;
               if (victim < 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  class_count[victim]--;
                  held--;
               end
            end
            default: begin
               if (held == 0) r.status = ST_EMPTY;
            end
         endcase
         c = top_class();
         if (c < 0) begin
            r.head_date = '0;
            r.head_code = '0;
         end else begin
            r.head_date = key_mem[c][head_ptr[c]];
            r.head_code = code_mem[c][head_ptr[c]];
         end
         r.count = CountOutW'(held);
         pending_reports.push_back(r);
      endfunction

      function void check_report(head_report_type got);
         head_report_type want;
         if (pending_reports.size() == 0) begin
            complain($sformatf("result beat with nothing pending: status %0d date %0d",
                               got.status, got.head_date));
         end else begin
            want = pending_reports.pop_front();
            if (got !== want)
               complain($sformatf(
                  "status %0d/%0d date %0d/%0d code %0d/%0d count %0d/%0d (want/got)",
                  want.status, got.status, want.head_date, got.head_date,
                  want.head_code, got.head_code, want.count, got.count));
         end
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic [63:0]         req_tdata   = '0;
   logic [1:0]          req_tuser   = '0;
   logic                rsp_tready  = 1'b0;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CsrDataW-1:0] csr_pwdata  = '0;
   wire logic                req_tready;
   wire logic                rsp_tvalid;
   wire logic [63:0]         rsp_tdata;
   wire logic [1:0]          rsp_tuser;
   wire logic [CsrDataW-1:0] csr_prdata;
   wire logic                csr_pready;

   head_report_board board;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_request  = 0;
   int          hold_left     = 0;
   int unsigned cycle_count   = 0;

   three_class_priority_queue_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("three_class_priority_queue_top_tb: errors");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      head_report_type got;
      if (rsp_tvalid === 1'b1 && rsp_tready) begin
         got.status    = status_type'(rsp_tuser);
         got.head_date = rsp_tdata[26:0];
         got.head_code = rsp_tdata[57:27];
         got.count     = rsp_tdata[62:58];
         board.check_report(got);
      end
      if (req_tvalid && req_tready === 1'b1)
         board.note_request(req_kind_type'(req_tuser), req_tdata[26:0], req_tdata[57:27]);
   end

   task automatic send_request(req_kind_type kind, logic [DateW-1:0] birth,
                               logic [CodeW-1:0] code);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, code, birth};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.outstanding() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [DateW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {5'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      board.set_register(index, value);
   endtask

   task automatic csr_read(logic [1:0] index);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      board.check_register(index, csr_prdata);
   endtask

   task automatic program_registers(logic [DateW-1:0] today, logic [DateW-1:0] elder,
                                    logic [DateW-1:0] child);
      wait_for_drain();
      csr_write(REG_TODAY, today);
      csr_write(REG_ELDER, elder);
      csr_write(REG_CHILD, child);
      csr_write(RegUnused, 27'($urandom));
      csr_read(REG_TODAY);
      csr_read(REG_ELDER);
      csr_read(REG_CHILD);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [DateW-1:0] pick_birth();
      longint t;
      longint e;
      longint c;
      longint span;
      longint b;
      t = {37'd0, board.today_date};
      e = {37'd0, board.elder_limit};
      c = {37'd0, board.child_limit};
      span = (e >= c) ? e - c + 1 : 1;
      case ($urandom_range(9))
         0:       b = {37'd0, 27'($urandom)};
         1:       b = t - e - 1 - $urandom_range(3);
         2:       b = t - e;
         3:       b = t - c;
         4:       b = t - c + 1;
         5:       b = t + $urandom_range(1000);
         6, 7:    b = t - e - $urandom_range(5000000);
         default: b = t - c - (longint'($urandom) % span);
      endcase
      return b[DateW-1:0];
   endfunction

   function automatic req_kind_type pick_kind(int insert_pct);
      int r;
      if ($urandom_range(99) < insert_pct) return REQ_INSERT;
      r = $urandom_range(99);
      if (r < 45) return REQ_POP_HEAD;
      if (r < 80) return REQ_POP_TAIL;
      return REQ_PEEK;
   endfunction

   task automatic run_phase(int send_pct, int recv_pct, bit with_hold);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      for (int n = 0; n < PhaseItems; n++) begin
         if (with_hold && n == 60) hold_request = 80;
         send_request(pick_kind(((n / 40) % 2 == 0) ? 75 : 30), pick_birth(),
                      31'($urandom));
      end
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_PEEK, '0, '0);
      send_request(REQ_POP_HEAD, '0, '0);
      send_request(REQ_POP_TAIL, '0, '0);
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_INSERT, '1, '1);
      send_request(REQ_INSERT, TodayReset - ChildReset, 31'($urandom));
      send_request(REQ_INSERT, TodayReset - ElderReset, 31'($urandom));
      send_request(REQ_INSERT, TodayReset - ElderReset - 1, 31'($urandom));
      send_request(REQ_INSERT, TodayReset - ChildReset + 1, 31'($urandom));
      send_request(REQ_PEEK, '0, '0);
      send_request(REQ_POP_TAIL, '0, '0);
      send_request(REQ_POP_HEAD, '0, '0);
      repeat (13) send_request(REQ_INSERT, 27'($urandom_range(99991231)), 31'($urandom));

      run_phase(0, 0, 1'b1);
      program_registers(DateMax, '0, '0);
      run_phase(55, 0, 1'b0);
      program_registers('0, DateMax, '0);
      run_phase(0, 55, 1'b0);
      program_registers(27'($urandom_range(99991231)), 27'($urandom_range(2000000)),
                        27'($urandom_range(300000)));
      run_phase(24, 24, 1'b0);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (board.mismatch_count == 0 && board.outstanding() == 0)
         $display("three_class_priority_queue_top_tb: clean");
      else
         $display("three_class_priority_queue_top_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
